// ----- hdl/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants of the first-fit slot allocator
// Holds the request and response payload types and the control word that
// the controller broadcasts to the row of slot cells.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int IDX_W = 6;
   localparam int FIELD_SLOTS = 64;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [IDX_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] granted_slot;
      logic             full_res;
      logic [IDX_W-1:0] end_index;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic down;
   } cell_ctl_type;

endpackage

// ----- hdl/ffsa_cell.sv -----
// ----------------------------------------------------------------------------
// ffsa_cell: one slot of the allocator chain
// Holds the slot's used flag and a search token. The token moves one cell
// per step toward the top or the bottom of the chain until it reaches a
// cell whose flag matches the search, where it stops and reports a hit.
// ----------------------------------------------------------------------------
module ffsa_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ffsa_pkg::cell_ctl_type ctl,
   input  logic                  inject,
   input  logic                  clear,
   input  logic                  pass_prev,
   input  logic                  pass_next,
   output logic                  pass_out,
   output logic                  hit
);

   logic flag_ff, flag_in;
   logic token_ff, token_in;

   assign hit      = token_ff & (flag_ff == ctl.down);
   assign pass_out = token_ff & ~hit;

   always_comb begin
      if (ctl.step) begin
         token_in = inject | (ctl.down ? pass_next : pass_prev);
      end else begin
         token_in = inject | token_ff;
      end
      flag_in = flag_ff;
      if (clear) begin
         flag_in = 1'b0;
      end else if (ctl.step && hit && !ctl.down) begin
         flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= 1'b0;
         token_ff <= 1'b0;
      end else begin
         flag_ff  <= flag_in;
         token_ff <= token_in;
      end
   end

endmodule

// ----- hdl/first_fit_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_slot_allocator: bitmap first-fit slot allocator
// A request transfer either allocates the lowest free slot or frees a named
// slot; each request gives exactly one response transfer carrying the
// granted slot, a full flag and the high-water end index after the request.
// One request is in work at a time; req_ready is high while the controller
// is idle, even when an earlier response is still waiting on rsp_ready.
// An allocate walks a token up the chain of slot cells from slot 0, one cell
// per cycle unless a waiting response holds it, and grants the first free
// slot it meets, or reports full when the last slot is used too.
// A free of a slot above 0 that hits the end index walks a token down from
// the slot below it to the next used slot, which becomes the new end index
// (0 if there is none); any other free answers without a search.
// The pool holds SLOTS slots, at most 64. Reset clears every used flag and
// the end index. While the response register is full and rsp_ready is low,
// the token in the chain holds its place.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator #(
   parameter int SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffsa_pkg::rsp_type rsp_data
);

   localparam int POOL = (SLOTS < ffsa_pkg::FIELD_SLOTS) ? SLOTS : ffsa_pkg::FIELD_SLOTS;
   localparam logic [ffsa_pkg::IDX_W:0] POOL_LIM = (ffsa_pkg::IDX_W + 1)'(POOL);
   localparam logic [ffsa_pkg::IDX_W-1:0] LAST = ffsa_pkg::IDX_W'(POOL - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic                        dir_ff, dir_in;
   logic [ffsa_pkg::IDX_W-1:0]  pos_ff, pos_in;
   logic [ffsa_pkg::IDX_W-1:0]  hw_ff, hw_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ffsa_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        accept;
   logic                        step;
   logic                        in_range;
   logic                        do_free;
   logic                        rollback;
   logic                        inject_en;
   logic [ffsa_pkg::IDX_W-1:0]  inject_idx;
   logic                        rsp_load;
   ffsa_pkg::rsp_type           rsp_next;
   ffsa_pkg::cell_ctl_type      ctl;
   logic [POOL-1:0]             hit;
   logic [POOL-1:0]             pass;
   logic [POOL-1:0]             prev_vec;
   logic [POOL-1:0]             next_vec;
   logic                        hit_any;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign step      = ~rsp_valid_ff | rsp_ready;
   assign in_range  = {1'b0, req_data.slot} < POOL_LIM;
   assign do_free   = accept && (req_data.opcode == ffsa_pkg::OP_FREE) && in_range;
   assign rollback  = do_free && (req_data.slot == hw_ff) && (req_data.slot != '0);
   assign inject_en = accept && ((req_data.opcode == ffsa_pkg::OP_ALLOC) || rollback);
   assign inject_idx = (req_data.opcode == ffsa_pkg::OP_ALLOC) ? '0 : req_data.slot - 1'b1;

   assign ctl.step = step;
   assign ctl.down = dir_ff;

   assign prev_vec = {pass[POOL-2:0], 1'b0};
   assign next_vec = {1'b0, pass[POOL-1:1]};
   assign hit_any  = |hit;

   for (genvar i = 0; i < POOL; i++) begin : g_cell
      ffsa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .inject    (inject_en && (inject_idx == ffsa_pkg::IDX_W'(i))),
         .clear     (do_free && (req_data.slot == ffsa_pkg::IDX_W'(i))),
         .pass_prev (prev_vec[i]),
         .pass_next (next_vec[i]),
         .pass_out  (pass[i]),
         .hit       (hit[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      pos_in   = pos_ff;
      hw_in    = hw_ff;
      rsp_load = 1'b0;
      rsp_next = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dir_in   = (req_data.opcode == ffsa_pkg::OP_FREE);
               pos_in   = inject_idx;
               state_in = inject_en ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (step) begin
               if (hit_any) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  if (dir_ff) begin
                     hw_in = pos_ff;
                     rsp_next.end_index = pos_ff;
                  end else begin
                     if (pos_ff > hw_ff) begin
                        hw_in = pos_ff;
                     end
                     rsp_next.granted_slot = pos_ff;
                     rsp_next.end_index    = (pos_ff > hw_ff) ? pos_ff : hw_ff;
                  end
               end else if (!dir_ff && (pos_ff == LAST)) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  rsp_next.full_res  = 1'b1;
                  rsp_next.end_index = hw_ff;
               end else if (dir_ff && (pos_ff == '0)) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  hw_in    = '0;
               end else begin
                  pos_in = dir_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (step) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               rsp_next.end_index = hw_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in       = rsp_next;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dir_ff       <= 1'b0;
         pos_ff       <= '0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         pos_ff       <= pos_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- verif/first_fit_slot_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_tb: self-checking bench for the slot allocator
// A short directed table walks the reset state, both slot extremes and the
// rollback of the end index. Random segments with changing allocate and free
// mixes follow, so the pool fills up, runs full and drains again. Each
// response is checked against fixed row values or a bench copy of used flags.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator_tb;

   localparam int SLOTS_UNDER_TEST = 64;
   localparam int POOL =
      (SLOTS_UNDER_TEST < ffsa_pkg::FIELD_SLOTS) ? SLOTS_UNDER_TEST : ffsa_pkg::FIELD_SLOTS;
   localparam int RANDOM_ITEMS = 1830;
   localparam int CALM_ITEMS = 250;
   localparam int DRAIN_CYCLES = 2 * POOL + 20;

   typedef struct packed {
      logic    opcode;
      logic [ffsa_pkg::IDX_W-1:0] slot;
      logic    fixed;
      ffsa_pkg::rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   ffsa_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   ffsa_pkg::rsp_type rsp_data;

   logic [ffsa_pkg::FIELD_SLOTS-1:0] slot_busy;
   logic [ffsa_pkg::IDX_W-1:0]       end_mark;
   ffsa_pkg::rsp_type                owed_rsp[$];
   stim_row_type                     stim_rows[0:16];
   int                               fail_count = 0;
   bit                               gaps_on;
   logic                             calm;
   int                               ready_hold = 0;

   first_fit_slot_allocator #(
      .SLOTS(SLOTS_UNDER_TEST)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic stim_row_type make_row(input logic op, input int slot,
                                             input logic fixed, input int granted,
                                             input logic full, input int end_index);
      stim_row_type row;
      row.opcode = op;
      row.slot = ffsa_pkg::IDX_W'(slot);
      row.fixed = fixed;
      row.want.granted_slot = ffsa_pkg::IDX_W'(granted);
      row.want.full_res = full;
      row.want.end_index = ffsa_pkg::IDX_W'(end_index);
      return row;
   endfunction

   // Applies one request to the bench copy of the pool and returns the
   // response the allocator owes for it.
   task automatic serve_request(input ffsa_pkg::req_type r, output ffsa_pkg::rsp_type o);
      int  k;
      bit  hit;
      o = '0;
      hit = 1'b0;
      if (r.opcode == ffsa_pkg::OP_ALLOC) begin
         for (k = 0; k < POOL; k++) begin
            if (!hit && !slot_busy[k]) begin
               hit = 1'b1;
               slot_busy[k] = 1'b1;
               if (k > end_mark) end_mark = ffsa_pkg::IDX_W'(k);
               o.granted_slot = ffsa_pkg::IDX_W'(k);
            end
         end
         o.full_res = !hit;
      end else if (r.slot < POOL) begin
         slot_busy[r.slot] = 1'b0;
         if (r.slot == end_mark) begin
            end_mark = '0;
            for (k = 0; k < r.slot; k++) begin
               if (slot_busy[k]) end_mark = ffsa_pkg::IDX_W'(k);
            end
         end
      end
      o.end_index = end_mark;
   endtask

   task automatic send_item(input ffsa_pkg::req_type item, input logic fixed,
                            input ffsa_pkg::rsp_type want);
      ffsa_pkg::rsp_type owed;
      if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      serve_request(item, owed);
      owed_rsp.push_back(fixed ? want : owed);
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("Mismatch on %s: expected %0d, got %0d.", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
         rsp_ready <= 1'b0;
         ready_hold = $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
         ready_hold = $urandom_range(0, 24);
      end
   end

   always @(posedge clock) begin
      ffsa_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (owed_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("Response transfer %h arrived with none outstanding.", rsp_data);
            end
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_data.granted_slot !== want.granted_slot) begin
               report_mismatch("granted_slot", want.granted_slot, rsp_data.granted_slot);
            end
            if (rsp_data.full_res !== want.full_res) begin
               report_mismatch("full_res", want.full_res, rsp_data.full_res);
            end
            if (rsp_data.end_index !== want.end_index) begin
               report_mismatch("end_index", want.end_index, rsp_data.end_index);
            end
         end
      end
   end

   initial begin
      ffsa_pkg::req_type item;
      int      n;
      int      k;
      int      pick;
      int      start;
      int      seg_left;
      int      alloc_pct;
      bit      found;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_ready <= 1'b0;
      calm <= 1'b0;
      slot_busy = '0;
      end_mark = '0;
      gaps_on = 1'b1;
      seg_left = 0;
      alloc_pct = 50;

      stim_rows[0]  = make_row(ffsa_pkg::OP_FREE,   0, 1'b1, 0, 1'b0, 0);
      stim_rows[1]  = make_row(ffsa_pkg::OP_FREE,  63, 1'b1, 0, 1'b0, 0);
      stim_rows[2]  = make_row(ffsa_pkg::OP_ALLOC, 63, 1'b1, 0, 1'b0, 0);
      stim_rows[3]  = make_row(ffsa_pkg::OP_ALLOC,  0, 1'b1, 1, 1'b0, 1);
      stim_rows[4]  = make_row(ffsa_pkg::OP_ALLOC, 42, 1'b1, 2, 1'b0, 2);
      stim_rows[5]  = make_row(ffsa_pkg::OP_ALLOC, 21, 1'b1, 3, 1'b0, 3);
      stim_rows[6]  = make_row(ffsa_pkg::OP_FREE,   1, 1'b0, 0, 1'b0, 0);
      stim_rows[7]  = make_row(ffsa_pkg::OP_ALLOC, 12, 1'b0, 0, 1'b0, 0);
      stim_rows[8]  = make_row(ffsa_pkg::OP_FREE,   3, 1'b0, 0, 1'b0, 0);
      stim_rows[9]  = make_row(ffsa_pkg::OP_FREE,   3, 1'b0, 0, 1'b0, 0);
      stim_rows[10] = make_row(ffsa_pkg::OP_FREE,   2, 1'b0, 0, 1'b0, 0);
      stim_rows[11] = make_row(ffsa_pkg::OP_FREE,   2, 1'b0, 0, 1'b0, 0);
      stim_rows[12] = make_row(ffsa_pkg::OP_FREE,   1, 1'b0, 0, 1'b0, 0);
      stim_rows[13] = make_row(ffsa_pkg::OP_FREE,   0, 1'b0, 0, 1'b0, 0);
      stim_rows[14] = make_row(ffsa_pkg::OP_FREE,   0, 1'b0, 0, 1'b0, 0);
      stim_rows[15] = make_row(ffsa_pkg::OP_ALLOC, 63, 1'b1, 0, 1'b0, 0);
      stim_rows[16] = make_row(ffsa_pkg::OP_FREE,   0, 1'b0, 0, 1'b0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < 17; n++) begin
         item.opcode = stim_rows[n].opcode;
         item.slot = stim_rows[n].slot;
         send_item(item, stim_rows[n].fixed, stim_rows[n].want);
      end

      // Each segment picks at random between filling, churning and draining the pool.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(16, 120);
            case ($urandom_range(0, 2))
               0: alloc_pct = 90;
               1: alloc_pct = 50;
               default: alloc_pct = 15;
            endcase
            gaps_on = $urandom_range(0, 3) != 0;
         end
         seg_left--;
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;

         item.slot = ffsa_pkg::IDX_W'($urandom_range(0, ffsa_pkg::FIELD_SLOTS - 1));
         if ($urandom_range(0, 99) < alloc_pct) begin
            item.opcode = ffsa_pkg::OP_ALLOC;
         end else begin
            item.opcode = ffsa_pkg::OP_FREE;
            pick = $urandom_range(0, 99);
            if (pick >= 15 && pick < 40) begin
               item.slot = end_mark;
            end else if (pick >= 40) begin
               start = $urandom_range(0, POOL - 1);
               found = 1'b0;
               for (k = 0; k < POOL; k++) begin
                  if (!found && slot_busy[(start + k) % POOL]) begin
                     found = 1'b1;
                     item.slot = ffsa_pkg::IDX_W'((start + k) % POOL);
                  end
               end
            end
         end
         send_item(item, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/ffsa_pkg.sv
hdl/ffsa_cell.sv
hdl/first_fit_slot_allocator.sv
verif/first_fit_slot_allocator_tb.sv
